FILE: rtl/gbpq_pkg.sv
`timescale 1ns / 1ps
// Package for the grid box point query block.
// Holds default sizes, operation codes and result status codes; no dependencies.
package gbpq_pkg;

    localparam int MAX_BOXES_DEF   = 256;
    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 32;
    localparam int CELL_SLOTS_DEF  = 16;
    localparam int MAX_HITS_DEF    = 16;

    localparam logic [3:0] SHIFT_RESET = 4'd5;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_MISS  = 3'd1,
        ST_FULL  = 3'd2,
        ST_OVF   = 3'd3,
        ST_CLEAR = 3'd4
    } status_t;

endpackage

FILE: rtl/gbpq_ram.sv
`timescale 1ns / 1ps
// Simple dual-port memory with one write port and one registered read port.
// Used for the box store, the cell fill counts and the cell slot lists.
module gbpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/grid_box_point_query.sv
`timescale 1ns / 1ps
// Top level of the grid box point query block: sequencer, box store and cell lists.
// Depends on gbpq_pkg and gbpq_ram.
// Clear sweeps the fill memory one cell a cycle, writing zero to every cell.
// Insert walks every covered cell with a fill read, then a write.
// Query walks the slot entries of the point's cell with a slot read, a box read and a compare.
// One item is in work at a time; the next is accepted once the last word is registered.
// After reset a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells runs before the first item.
module grid_box_point_query
    import gbpq_pkg::*;
#(
    parameter int MAX_BOXES   = MAX_BOXES_DEF,
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int CELL_SLOTS  = CELL_SLOTS_DEF,
    parameter int MAX_HITS    = MAX_HITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // box_min_x, box_min_y, box_max_x, box_max_y, point_x, point_y
    input  logic [95:0] s_tdata,
    // op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit_min_x, hit_min_y, hit_max_x, hit_max_y, box_index
    output logic [71:0] m_tdata,
    // status
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int CW     = $clog2(NCELLS);
    localparam int AW     = $clog2(NCELLS * CELL_SLOTS);
    localparam int IW     = $clog2(MAX_BOXES);
    localparam int CNTW   = $clog2(MAX_BOXES + 1);
    localparam int FW     = $clog2(CELL_SLOTS + 1);
    localparam int HW     = $clog2(MAX_HITS + 1);
    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_INS_SET, S_INS_RD, S_INS_WR,
        S_Q_CELL, S_Q_RD, S_Q_FILL, S_Q_SLOT, S_Q_IDX, S_Q_CMP, S_FIN
    } state_t;

    state_t               state_reg;
    logic                 ack_reg;
    logic [CW-1:0]        clr_reg;
    logic [3:0]           shift_reg;
    logic [CNTW-1:0]      count_reg;
    logic signed [15:0]   bx0_reg, by0_reg, bx1_reg, by1_reg;
    logic signed [15:0]   px_reg, py_reg;
    logic [IW-1:0]        idx_reg;
    logic [CW-1:0]        cell_reg;
    logic [XW-1:0]        cx_reg, cx0_reg, cx1_reg;
    logic [YW-1:0]        cy_reg, cy1_reg;
    logic [FW-1:0]        i_reg, fill_reg;
    logic [HW-1:0]        hits_reg;
    status_t              fin_reg;
    logic                 ovf_reg;

    logic                 m_tvalid_reg, m_tlast_reg;
    logic [71:0]          m_tdata_reg;
    logic [2:0]           m_tuser_reg;

    logic                 out_free;
    logic                 box_we, fill_we, slot_we;
    logic [CW-1:0]        fill_waddr;
    logic [FW-1:0]        fill_wdata, fill_rdata;
    logic [AW-1:0]        slot_waddr, slot_raddr;
    logic [IW-1:0]        slot_rdata;
    logic [63:0]          box_rdata;

    logic signed [16:0]   vx0, vy0, vx1, vy1;
    logic signed [16:0]   kx0, ky0, kx1, ky1, qx, qy;
    logic                 covers, q_in;
    logic [XW-1:0]        ccx0, ccx1, qcx;
    logic [YW-1:0]        ccy0, ccy1, qcy;
    logic signed [15:0]   hx0, hy0, hx1, hy1;
    logic                 hit;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    // Cell coordinates are floor(v / 2^shift), taken as an arithmetic shift.
    always_comb
    begin
        vx0 = 17'(bx0_reg);
        vy0 = 17'(by0_reg);
        vx1 = 17'(bx1_reg) - 17'sd1;
        vy1 = 17'(by1_reg) - 17'sd1;
        kx0 = vx0 >>> shift_reg;
        ky0 = vy0 >>> shift_reg;
        kx1 = vx1 >>> shift_reg;
        ky1 = vy1 >>> shift_reg;
        qx  = 17'(px_reg) >>> shift_reg;
        qy  = 17'(py_reg) >>> shift_reg;
        covers = (kx1 >= 0) && (ky1 >= 0) && (kx0 < GRID_WIDTH) && (ky0 < GRID_HEIGHT)
                 && (kx0 <= kx1) && (ky0 <= ky1);
        ccx0 = (kx0 < 0) ? '0 : kx0[XW-1:0];
        ccy0 = (ky0 < 0) ? '0 : ky0[YW-1:0];
        ccx1 = (kx1 >= GRID_WIDTH) ? XW'(GRID_WIDTH - 1) : kx1[XW-1:0];
        ccy1 = (ky1 >= GRID_HEIGHT) ? YW'(GRID_HEIGHT - 1) : ky1[YW-1:0];
        q_in = (qx >= 0) && (qy >= 0) && (qx < GRID_WIDTH) && (qy < GRID_HEIGHT);
        qcx  = qx[XW-1:0];
        qcy  = qy[YW-1:0];
        hx0 = $signed(box_rdata[15:0]);
        hy0 = $signed(box_rdata[31:16]);
        hx1 = $signed(box_rdata[47:32]);
        hy1 = $signed(box_rdata[63:48]);
        hit = (px_reg >= hx0) && (px_reg <= hx1) && (py_reg >= hy0) && (py_reg <= hy1);
    end

    always_comb
    begin
        box_we     = (state_reg == S_IDLE) && s_tvalid && (s_tuser == OP_INSERT)
                     && (count_reg < CNTW'(MAX_BOXES));
        fill_we    = (state_reg == S_CLR)
                     || ((state_reg == S_INS_WR) && (fill_rdata < FW'(CELL_SLOTS)));
        fill_waddr = (state_reg == S_CLR) ? clr_reg : cell_reg;
        fill_wdata = (state_reg == S_CLR) ? '0 : fill_rdata + FW'(1);
        slot_we    = (state_reg == S_INS_WR) && (fill_rdata < FW'(CELL_SLOTS));
        slot_waddr = AW'(cell_reg) * AW'(CELL_SLOTS) + AW'(fill_rdata);
        slot_raddr = AW'(cell_reg) * AW'(CELL_SLOTS) + AW'(i_reg);
    end

    gbpq_ram #(.WIDTH(64), .DEPTH(MAX_BOXES)) u_box_ram (
        .clk   (clk),
        .we    (box_we),
        .waddr (count_reg[IW-1:0]),
        .wdata ({s_tdata[63:48], s_tdata[47:32], s_tdata[31:16], s_tdata[15:0]}),
        .raddr (slot_rdata),
        .rdata (box_rdata)
    );

    gbpq_ram #(.WIDTH(FW), .DEPTH(NCELLS)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (cell_reg),
        .rdata (fill_rdata)
    );

    gbpq_ram #(.WIDTH(IW), .DEPTH(NCELLS * CELL_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (idx_reg),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            ack_reg      <= 1'b0;
            clr_reg      <= '0;
            shift_reg    <= SHIFT_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            hits_reg     <= '0;
            ovf_reg      <= 1'b0;
            fin_reg      <= ST_OK;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                shift_reg <= cfg_data;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == CW'(NCELLS - 1))
                    begin
                        clr_reg <= '0;
                        if (ack_reg)
                        begin
                            fin_reg <= ST_CLEAR;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_IDLE:
                begin
                    bx0_reg  <= $signed(s_tdata[15:0]);
                    by0_reg  <= $signed(s_tdata[31:16]);
                    bx1_reg  <= $signed(s_tdata[47:32]);
                    by1_reg  <= $signed(s_tdata[63:48]);
                    px_reg   <= $signed(s_tdata[79:64]);
                    py_reg   <= $signed(s_tdata[95:80]);
                    idx_reg  <= count_reg[IW-1:0];
                    hits_reg <= '0;
                    ovf_reg  <= 1'b0;
                    if (s_tvalid)
                    begin
                        case (s_tuser)
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                ack_reg   <= 1'b1;
                                idx_reg   <= '0;
                                bx0_reg   <= '0;
                                by0_reg   <= '0;
                                bx1_reg   <= '0;
                                by1_reg   <= '0;
                                state_reg <= S_CLR;
                            end
                            OP_INSERT:
                            begin
                                if (count_reg < CNTW'(MAX_BOXES))
                                begin
                                    count_reg <= count_reg + CNTW'(1);
                                    state_reg <= S_INS_SET;
                                end
                                else
                                begin
                                    idx_reg   <= '0;
                                    bx0_reg   <= '0;
                                    by0_reg   <= '0;
                                    bx1_reg   <= '0;
                                    by1_reg   <= '0;
                                    fin_reg   <= ST_FULL;
                                    state_reg <= S_FIN;
                                end
                            end
                            OP_QUERY:
                            begin
                                state_reg <= S_Q_CELL;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INS_SET:
                begin
                    cx_reg   <= ccx0;
                    cx0_reg  <= ccx0;
                    cx1_reg  <= ccx1;
                    cy_reg   <= ccy0;
                    cy1_reg  <= ccy1;
                    cell_reg <= CW'(ccy0) * CW'(GRID_WIDTH) + CW'(ccx0);
                    fin_reg  <= ST_OK;
                    state_reg <= covers ? S_INS_RD : S_FIN;
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_WR;
                end
                S_INS_WR:
                begin
                    if (fill_rdata >= FW'(CELL_SLOTS))
                    begin
                        ovf_reg <= 1'b1;
                    end
                    state_reg <= S_INS_RD;
                    if (cx_reg == cx1_reg)
                    begin
                        cx_reg   <= cx0_reg;
                        cy_reg   <= cy_reg + YW'(1);
                        cell_reg <= CW'(cy_reg + YW'(1)) * CW'(GRID_WIDTH) + CW'(cx0_reg);
                        if (cy_reg == cy1_reg)
                        begin
                            if (ovf_reg || (fill_rdata >= FW'(CELL_SLOTS)))
                            begin
                                fin_reg <= ST_OVF;
                            end
                            state_reg <= S_FIN;
                        end
                    end
                    else
                    begin
                        cx_reg   <= cx_reg + XW'(1);
                        cell_reg <= CW'(cy_reg) * CW'(GRID_WIDTH) + CW'(cx_reg + XW'(1));
                    end
                end
                S_Q_CELL:
                begin
                    cell_reg <= CW'(qcy) * CW'(GRID_WIDTH) + CW'(qcx);
                    i_reg    <= '0;
                    idx_reg  <= '0;
                    bx0_reg  <= '0;
                    by0_reg  <= '0;
                    bx1_reg  <= '0;
                    by1_reg  <= '0;
                    fin_reg  <= ST_MISS;
                    state_reg <= q_in ? S_Q_RD : S_FIN;
                end
                S_Q_RD:
                begin
                    state_reg <= S_Q_FILL;
                end
                S_Q_FILL:
                begin
                    fill_reg  <= fill_rdata;
                    state_reg <= (fill_rdata == '0) ? S_FIN : S_Q_SLOT;
                end
                S_Q_SLOT:
                begin
                    state_reg <= S_Q_IDX;
                end
                S_Q_IDX:
                begin
                    state_reg <= S_Q_CMP;
                end
                S_Q_CMP:
                begin
                    if (!(hit && (hits_reg != '0) && !out_free))
                    begin
                        if (hit)
                        begin
                            if (hits_reg != '0)
                            begin
                                m_tvalid_reg <= 1'b1;
                                m_tuser_reg  <= ST_OK;
                                m_tlast_reg  <= 1'b0;
                                m_tdata_reg  <= {8'(idx_reg), by1_reg, bx1_reg, by0_reg, bx0_reg};
                            end
                            bx0_reg  <= hx0;
                            by0_reg  <= hy0;
                            bx1_reg  <= hx1;
                            by1_reg  <= hy1;
                            idx_reg  <= slot_rdata;
                            hits_reg <= hits_reg + HW'(1);
                            fin_reg  <= ST_OK;
                        end
                        if ((i_reg + FW'(1) == fill_reg)
                            || (hit && (hits_reg + HW'(1) == HW'(MAX_HITS))))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            i_reg     <= i_reg + FW'(1);
                            state_reg <= S_Q_SLOT;
                        end
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= fin_reg;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= {8'(idx_reg), by1_reg, bx1_reg, by0_reg, bx0_reg};
                        ack_reg      <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/gbpq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for grid_box_point_query, attached by the bind at the end.
// Depends on gbpq_pkg for the status and operation codes.
module gbpq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import gbpq_pkg::*;

    // A stalled result word holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // The block works on one word at a time; an unused operation is dropped at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != OP_UNUSED) |=> !s_tready)
        else $error("input accepted while busy");

    // Every status other than a hit ends the item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> m_tlast)
        else $error("non-hit status without last");

    // Only defined status codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_MISS) || (m_tuser == ST_FULL)
                     || (m_tuser == ST_OVF) || (m_tuser == ST_CLEAR))
        else $error("undefined status code");

endmodule

bind grid_box_point_query gbpq_checker u_gbpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
